// ===== hw/rtl/smac_pkg.sv =====
// Shared types and constants for the sorted MAC address set.
`default_nettype none
package smac_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int KEY_W    = 48;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd4;
  localparam logic [STAT_W-1:0] ST_READ_OK  = 3'd5;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd6;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd7;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
  } smac_ctl_t;

  // per-cell compare flags, registered inside the cell
  typedef struct packed {
    logic lt;
    logic eq;
    logic hit;
  } smac_flags_t;

endpackage : smac_pkg
`default_nettype wire

// ===== hw/rtl/smac_cell.sv =====
// One slot of the sorted table: holds an address, compares it, shifts on insert.
`default_nettype none
module smac_cell
  import smac_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire smac_ctl_t        ctl,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic [IDX_W-1:0] rank,
  input  wire logic             prev_lt,
  input  wire logic [KEY_W-1:0] prev_entry,
  output smac_flags_t           flags,
  output logic [KEY_W-1:0]      entry
);

  logic [KEY_W-1:0] entry_r;
  logic [KEY_W-1:0] entry_nxt;
  smac_flags_t      flags_r;
  smac_flags_t      flags_nxt;
  logic             occ;

  assign occ = {{(CNT_W-IDX_W){1'b0}}, cell_idx} < count;

  always_comb begin
    flags_nxt     = flags_r;
    if (ctl.cmp_en) begin
      flags_nxt.lt  = occ && (entry_r < key);
      flags_nxt.eq  = occ && (entry_r == key);
      flags_nxt.hit = occ && (cell_idx == rank);
    end
  end

  // cells at or above the insert point take the key or the left neighbor's entry
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en && !flags_r.lt) begin
      entry_nxt = prev_lt ? key : prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign flags = flags_r;
  assign entry = entry_r;

endmodule : smac_cell
`default_nettype wire

// ===== hw/rtl/sorted_mac_address_set_core.sv =====
// Top level of the sorted MAC address set: sequencer, count and a row of cells.
//
// Input channel in_valid/in_ready carries one command item: in_cmd (insert,
// lookup, read by rank, clear), in_key and in_rank. Result channel
// out_valid/out_ready returns exactly one item per command: out_status,
// out_entry_value, out_entry_count and out_is_full.
// cfg_valid/cfg_ready writes the entry limit (cfg_data, 0 = full capacity);
// cfg_ready is always high.
// An item passes through accept (idle), a compare state in which every cell
// registers its less-than, equal and rank-hit flags against the broadcast key
// and rank, and an execute state that reduces the flags, shifts the row on a
// successful insert and loads the result register. The result is visible the
// cycle after the execute cycle. in_ready is high only while the sequencer is
// idle, so no new item is taken until the last one has committed its result.
// If the result register still holds an untaken item, the execute cycle
// waits for out_ready; nothing is lost or repeated.
// Synchronous reset empties the table (count to zero), sets the limit to
// zero and drops any pending result. Stored addresses are not cleared.
`default_nettype none
module sorted_mac_address_set_core
  import smac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [KEY_W-1:0]  in_key,
  input  wire logic [IDX_W-1:0]  in_rank,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      out_status,
  output logic [KEY_W-1:0]       out_entry_value,
  output logic [CNT_W-1:0]       out_entry_count,
  output logic                   out_is_full,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]  cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [1:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [IDX_W-1:0]  rank_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  max_entries_r;
  logic [CNT_W-1:0]  limit;

  logic              out_valid_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [KEY_W-1:0]  value_r, value_nxt;
  logic [CNT_W-1:0]  ocount_r;
  logic              full_r;

  smac_ctl_t         ctl;
  smac_flags_t       flags_arr [CAPACITY];
  logic [KEY_W-1:0]  entry_arr [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic [KEY_W-1:0]  read_value;
  logic              any_eq;
  logic              commit;
  logic              full_now;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign commit    = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign limit    = ((max_entries_r == '0) || (max_entries_r > CAP_CNT)) ? CAP_CNT
                                                                        : max_entries_r;
  assign full_now = (count_r >= limit);

  always_comb begin
    read_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      eq_vec[i]  = flags_arr[i].eq;
      read_value = read_value | (entry_arr[i] & {KEY_W{flags_arr[i].hit}});
    end
  end
  assign any_eq = |eq_vec;

  always_comb begin
    ctl.cmp_en = (state_r == S_CMP);
    ctl.ins_en = commit && (cmd_r == CMD_INSERT) && !full_now && !any_eq;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic             prev_lt;
      logic [KEY_W-1:0] prev_entry;
      if (g == 0) begin : g_head
        assign prev_lt    = 1'b1;
        assign prev_entry = key_r;
      end else begin : g_link
        assign prev_lt    = flags_arr[g-1].lt;
        assign prev_entry = entry_arr[g-1];
      end
      smac_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cell_idx   (IDX_W'(g)),
        .count      (count_r),
        .key        (key_r),
        .rank       (rank_r),
        .prev_lt    (prev_lt),
        .prev_entry (prev_entry),
        .flags      (flags_arr[g]),
        .entry      (entry_arr[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_CLEARED;
    value_nxt  = '0;
    unique case (cmd_r)
      CMD_INSERT: begin
        priority if (full_now) begin
          status_nxt = ST_FULL;
        end else if (any_eq) begin
          status_nxt = ST_DUP;
        end else begin
          status_nxt = ST_INSERTED;
          count_nxt  = count_r + 1'b1;
        end
      end
      CMD_LOOKUP: begin
        status_nxt = any_eq ? ST_FOUND : ST_ABSENT;
      end
      CMD_READ: begin
        if ({{(CNT_W-IDX_W){1'b0}}, rank_r} < count_r) begin
          status_nxt = ST_READ_OK;
          value_nxt  = read_value;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      CMD_CLEAR: begin
        status_nxt = ST_CLEARED;
        count_nxt  = '0;
      end
      default: begin
        status_nxt = ST_CLEARED;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_EXEC;
      S_EXEC:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      max_entries_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        max_entries_r <= cfg_data;
      end
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      key_r  <= in_key;
      rank_r <= in_rank;
    end
    if (commit) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      ocount_r <= count_nxt;
      full_r   <= (count_nxt >= limit);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_value = value_r;
  assign out_entry_count = ocount_r;
  assign out_is_full     = full_r;

endmodule : sorted_mac_address_set_core
`default_nettype wire

// ===== hw/rtl/smac_checker.sv =====
// Port-level checks for the sorted MAC address set, bound to the top level.
`default_nettype none
module smac_checker
  import smac_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic [KEY_W-1:0]  out_entry_value,
  input wire logic [CNT_W-1:0]  out_entry_count,
  input wire logic              out_is_full
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_entry_count))
    else $error("result changed while stalled");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_READ_OK) |-> (out_entry_value == '0))
    else $error("entry value nonzero outside a successful read");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_INSERTED) |-> (out_entry_count != '0))
    else $error("insert reported with empty table");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_CLEARED) |-> (out_entry_count == '0) && !out_is_full)
    else $error("clear left entries or full flag");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_is_full)
    else $error("full refusal without full flag");

endmodule : smac_checker

bind sorted_mac_address_set_core smac_checker u_smac_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_entry_value (out_entry_value),
  .out_entry_count (out_entry_count),
  .out_is_full     (out_is_full)
);
`default_nettype wire

// ===== tb/sv/sorted_mac_set_checker.sv =====
// Checker for the sorted MAC address set: shadow table, answer prediction and comparison.
`timescale 1ns / 100ps
module sorted_mac_set_checker
  import smac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [IDX_W-1:0]  in_rank,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [STAT_W-1:0] out_status,
  input  logic [KEY_W-1:0]  out_entry_value,
  input  logic [CNT_W-1:0]  out_entry_count,
  input  logic              out_is_full,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  output int                errors,
  output int                answers_waiting
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  value;
    logic [CNT_W-1:0]  count;
    logic              full;
  } set_answer_t;

  logic [KEY_W-1:0] shadow_macs [CAPACITY];
  int unsigned      shadow_count;
  logic [CNT_W-1:0] limit_reg;
  set_answer_t      answers_due[$];
  set_answer_t      want;

  // Apply one command to the shadow table and return the answer it must produce.
  function automatic set_answer_t answer_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [IDX_W-1:0] rank);
    set_answer_t ans;
    int unsigned cap;
    int unsigned pos;
    logic        present;
    ans = '0;
    cap = (limit_reg == 0 || limit_reg > CAPACITY) ? CAPACITY : limit_reg;
    pos = 0;
    while (pos < shadow_count && shadow_macs[pos] < key) pos++;
    present = (pos < shadow_count) && (shadow_macs[pos] == key);
    case (cmd)
      CMD_INSERT: begin
        // full wins over duplicate
        if (shadow_count >= cap) begin
          ans.status = ST_FULL;
        end else if (present) begin
          ans.status = ST_DUP;
        end else begin
          for (int i = shadow_count; i > pos; i--) shadow_macs[i] = shadow_macs[i-1];
          shadow_macs[pos] = key;
          shadow_count++;
          ans.status = ST_INSERTED;
        end
      end
      CMD_LOOKUP: ans.status = present ? ST_FOUND : ST_ABSENT;
      CMD_READ: begin
        if (rank < shadow_count) begin
          ans.status = ST_READ_OK;
          ans.value  = shadow_macs[rank];
        end else begin
          ans.status = ST_RANGE;
        end
      end
      default: begin
        shadow_count = 0;
        ans.status   = ST_CLEARED;
      end
    endcase
    ans.count = CNT_W'(shadow_count);
    ans.full  = shadow_count >= cap;
    return ans;
  endfunction

  initial begin
    errors          = 0;
    answers_waiting = 0;
    shadow_count    = 0;
    limit_reg       = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      limit_reg    = '0;
      answers_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          errors++;
          $error("result item with nothing outstanding: status %0d", out_status);
        end else begin
          want = answers_due.pop_front();
          if (out_status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, out_status);
          end
          if (out_entry_value !== want.value) begin
            errors++;
            $error("entry_value: expected %h, got %h", want.value, out_entry_value);
          end
          if (out_entry_count !== want.count) begin
            errors++;
            $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
          end
          if (out_is_full !== want.full) begin
            errors++;
            $error("is_full: expected %0d, got %0d", want.full, out_is_full);
          end
        end
      end
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (in_valid && in_ready) answers_due.push_back(answer_command(in_cmd, in_key, in_rank));
    end
    answers_waiting = answers_due.size();
  end

endmodule

// ===== tb/sv/sorted_mac_address_set_core_tb.sv =====
// Testbench top for the sorted MAC address set: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module sorted_mac_address_set_core_tb;
  import smac_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd;
  logic [KEY_W-1:0]  in_key;
  logic [IDX_W-1:0]  in_rank;
  logic              out_valid;
  logic              out_ready;
  logic [STAT_W-1:0] out_status;
  logic [KEY_W-1:0]  out_entry_value;
  logic [CNT_W-1:0]  out_entry_count;
  logic              out_is_full;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data;

  int errors;
  int answers_waiting;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int stuck_cycles;
  logic [KEY_W-1:0] seen_macs[$];

  always #2 clk = ~clk;

  sorted_mac_address_set_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_rank         (in_rank),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_entry_count (out_entry_count),
    .out_is_full     (out_is_full),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  sorted_mac_set_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_rank         (in_rank),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_entry_count (out_entry_count),
    .out_is_full     (out_is_full),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .errors          (errors),
    .answers_waiting (answers_waiting)
  );

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("sorted_mac_address_set_core_tb: errors");
        $finish;
      end
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [IDX_W-1:0] rank);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_rank  <= rank;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_CLEAR) seen_macs.delete();
    if (cmd == CMD_INSERT) begin
      seen_macs.push_back(key);
      if (seen_macs.size() > 96) void'(seen_macs.pop_front());
    end
  endtask

  // Drop valid and wait until every result item has been taken.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (answers_waiting != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] limit);
    settle_block();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int pool_pct);
    logic [63:0]      raw;
    logic [KEY_W-1:0] k;
    raw = {$urandom(), $urandom()};
    k   = raw[KEY_W-1:0];
    if (seen_macs.size() != 0 && $urandom_range(0, 99) < pool_pct) begin
      k = seen_macs[$urandom_range(0, seen_macs.size() - 1)];
      // near misses next to stored keys
      if ($urandom_range(0, 5) == 0) k = k + 1;
      return k;
    end
    case ($urandom_range(0, 9))
      0: k = '0;
      1: k = '1;
      2: k = KEY_W'($urandom_range(0, 15));
      3: k = {raw[7:0], 40'h0};
      default: ;
    endcase
    return k;
  endfunction

  task automatic run_mixed(input int n, input int ins_pct, input int clr_pct,
                           input int pool_pct);
    int r;
    int top_rank;
    for (int i = 0; i < n; i++) begin
      r        = $urandom_range(0, 99);
      top_rank = (seen_macs.size() + 2 > 63) ? 63 : seen_macs.size() + 2;
      if (r < clr_pct) begin
        send_command(CMD_CLEAR, pick_key(0), IDX_W'($urandom_range(0, 63)));
      end else if (r < clr_pct + ins_pct) begin
        send_command(CMD_INSERT, pick_key(pool_pct), IDX_W'($urandom_range(0, 63)));
      end else if ($urandom_range(0, 1) == 0) begin
        send_command(CMD_LOOKUP, pick_key(60), IDX_W'($urandom_range(0, 63)));
      end else if ($urandom_range(0, 3) == 0) begin
        send_command(CMD_READ, pick_key(0), IDX_W'($urandom_range(0, 63)));
      end else begin
        send_command(CMD_READ, pick_key(0), IDX_W'($urandom_range(0, top_rank)));
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = CMD_LOOKUP;
    in_key        = '0;
    in_rank       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    hold_left     = 0;
    stuck_cycles  = 0;
    send_idle_pct = 16;
    recv_idle_pct = 80;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty table, extremes, ordering on the first byte, duplicates
    send_command(CMD_READ, '0, '0);
    send_command(CMD_LOOKUP, '0, '0);
    send_command(CMD_INSERT, '0, '1);
    send_command(CMD_INSERT, '1, '0);
    send_command(CMD_INSERT, '0, '0);
    send_command(CMD_INSERT, 48'h01_00_00_00_00_00, '0);
    send_command(CMD_INSERT, 48'h00_FF_FF_FF_FF_FF, '0);
    send_command(CMD_INSERT, 48'hAA_AA_AA_AA_AA_AA, '0);
    send_command(CMD_INSERT, 48'h55_55_55_55_55_55, '0);
    for (int r = 0; r < 7; r++) send_command(CMD_READ, '0, IDX_W'(r));
    send_command(CMD_READ, '1, '1);
    send_command(CMD_LOOKUP, '1, '0);
    send_command(CMD_LOOKUP, 48'h01_00_00_00_00_01, '0);
    send_command(CMD_CLEAR, '1, '1);
    send_command(CMD_READ, '0, '0);
    send_command(CMD_LOOKUP, '0, '0);

    // small limit: full refusal ahead of duplicate
    write_limit(CNT_W'(2));
    send_command(CMD_INSERT, 48'h00_00_00_00_01_23, '0);
    send_command(CMD_INSERT, 48'h00_00_00_00_04_56, '0);
    send_command(CMD_INSERT, 48'h00_00_00_00_07_89, '0);
    send_command(CMD_INSERT, 48'h00_00_00_00_01_23, '0);
    send_command(CMD_LOOKUP, 48'h00_00_00_00_04_56, '0);
    // limit lowered below the count keeps the entries
    write_limit(CNT_W'(1));
    send_command(CMD_INSERT, 48'h00_00_00_00_00_01, '0);
    send_command(CMD_READ, '0, IDX_W'(1));

    write_limit(CNT_W'(5));
    run_mixed(150, 45, 5, 40);

    send_idle_pct = 80;
    recv_idle_pct = 16;
    write_limit('0);
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    run_mixed(250, 60, 1, 15);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit('1);
    run_mixed(120, 50, 2, 40);
    write_limit(CNT_W'(1));
    run_mixed(60, 45, 8, 40);
    write_limit(CNT_W'(CAPACITY));
    run_mixed(60, 50, 2, 40);
    write_limit(CNT_W'(33));
    run_mixed(60, 55, 2, 30);

    settle_block();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("sorted_mac_address_set_core_tb: clean");
    end else begin
      $display("sorted_mac_address_set_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/smac_pkg.sv
hw/rtl/smac_cell.sv
hw/rtl/sorted_mac_address_set_core.sv
hw/rtl/smac_checker.sv
tb/sv/sorted_mac_set_checker.sv
tb/sv/sorted_mac_address_set_core_tb.sv
